// ----- rtl/core/hsv_range_key_pixel_filter_macros.svh -----
// Assertion macros shared by the HSV keying filter RTL.
`ifndef HSV_RANGE_KEY_PIXEL_FILTER_MACROS_SVH
`define HSV_RANGE_KEY_PIXEL_FILTER_MACROS_SVH
`ifndef SYNTHESIS
`define HSVK_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hsvk: implication check failed");
`define HSVK_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hsvk: next-cycle check failed");
`else
`define HSVK_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HSVK_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/core/hsvk_pkg.sv -----
// Types, constants and helpers for the HSV keying filter.
package hsvk_pkg;

	localparam int CH_W       = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;

	// restoring divider geometry: 17-bit dividend, 9-bit divisor, 8-bit quotient
	localparam int DIV_NUM_W = 17;
	localparam int DIV_DEN_W = 9;
	localparam int DIV_Q_W   = 8;

	// channel rebuild: value * coef / 7650, round half up
	localparam int          COEF_W     = 13;
	localparam int          XNUM_W     = 21;
	localparam logic [12:0] COEF_DEN   = 13'd7650;
	localparam logic [20:0] ROUND_HALF = 21'd3825;

	// floor(x / 3825) = (x * RECIP_M) >> 32, exact for x < 2^20
	localparam int          RECIP_M    = 1122868;
	localparam int          RECIP_LO_W = 11;
	localparam logic [10:0] RECIP_M_LO = 11'(RECIP_M % 2048);
	localparam logic [9:0]  RECIP_M_HI = 10'(RECIP_M / 2048);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HUE_MIN = 3'd0,
		REG_HUE_MAX = 3'd1,
		REG_SAT_MIN = 3'd2,
		REG_SAT_MAX = 3'd3,
		REG_VAL_MIN = 3'd4,
		REG_VAL_MAX = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		SEC_RED_YEL = 3'd0,
		SEC_YEL_GRN = 3'd1,
		SEC_GRN_CYN = 3'd2,
		SEC_CYN_BLU = 3'd3,
		SEC_BLU_MAG = 3'd4,
		SEC_MAG_RED = 3'd5,
		SEC_WRAP    = 3'd6
	} sector_t;

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
	} pix_out_t;

	// per-pixel flags riding alongside the arithmetic
	typedef struct packed {
		logic       kill;
		logic       grey;
		logic [7:0] vv;
	} side_t;

	typedef struct packed {
		sector_t    sec;
		logic [4:0] fr;
	} sect_t;

	// split half-degree hue (0..180) into sector and offset within it
	function automatic sect_t hsvk_sector(input logic [7:0] hq);
		sect_t      s;
		logic [7:0] base;
		s.sec = SEC_RED_YEL;
		base  = '0;
		for (int i = 1; i <= 6; i++) begin
			if (hq >= 8'(30 * i)) begin
				s.sec = sector_t'(3'(i));
				base  = 8'(30 * i);
			end
		end
		s.fr = 5'(hq - base);
		return s;
	endfunction

endpackage

// ----- rtl/core/hsvk_div.sv -----
// Eight-stage pipelined restoring divider, one quotient bit per stage.
module hsvk_div (
	input  logic                                clk,
	input  logic [hsvk_pkg::DIV_NUM_W-1:0]      num,
	input  logic [hsvk_pkg::DIV_DEN_W-1:0]      den,
	output logic [hsvk_pkg::DIV_Q_W-1:0]        quot
);

	logic [hsvk_pkg::DIV_NUM_W-1:0] rem_s  [hsvk_pkg::DIV_Q_W];
	logic [hsvk_pkg::DIV_Q_W-1:0]   quot_s [hsvk_pkg::DIV_Q_W];
	logic [hsvk_pkg::DIV_DEN_W-1:0] den_s  [hsvk_pkg::DIV_Q_W-1];

	for (genvar k = 0; k < hsvk_pkg::DIV_Q_W; k++) begin : g_stage
		localparam int SH = hsvk_pkg::DIV_Q_W - 1 - k;
		logic [hsvk_pkg::DIV_NUM_W-1:0] r_in;
		logic [hsvk_pkg::DIV_DEN_W-1:0] d_in;
		logic [hsvk_pkg::DIV_Q_W-1:0]   q_in;
		logic [hsvk_pkg::DIV_NUM_W-1:0] trial;

		if (k == 0) begin : g_first
			assign r_in = num;
			assign d_in = den;
			assign q_in = '0;
		end else begin : g_next
			assign r_in = rem_s[k-1];
			assign d_in = den_s[k-1];
			assign q_in = quot_s[k-1];
		end

		assign trial = hsvk_pkg::DIV_NUM_W'(d_in) << SH;

		always_ff @(posedge clk) begin
			if (r_in >= trial) begin
				rem_s[k]  <= r_in - trial;
				quot_s[k] <= q_in | (hsvk_pkg::DIV_Q_W'(1) << SH);
			end else begin
				rem_s[k]  <= r_in;
				quot_s[k] <= q_in;
			end
		end

		if (k < hsvk_pkg::DIV_Q_W - 1) begin : g_den
			always_ff @(posedge clk) begin
				den_s[k] <= d_in;
			end
		end
	end

	assign quot = quot_s[hsvk_pkg::DIV_Q_W-1];

endmodule

// ----- rtl/core/hsvk_recip.sv -----
// Two-stage truncating (floor) divide by 7650 via reciprocal multiply.
module hsvk_recip (
	input  logic                            clk,
	input  logic [hsvk_pkg::XNUM_W-1:0]     x,
	output logic [7:0]                      q
);

	localparam int XH_W = hsvk_pkg::XNUM_W - 1;

	logic [XH_W-1:0]                        xh;
	logic [XH_W+hsvk_pkg::RECIP_LO_W-1:0]   plo_s1;
	logic [XH_W+9:0]                        phi_s1;
	logic [XH_W+hsvk_pkg::RECIP_LO_W+9:0]   sum;
	logic [7:0]                             q_s2;

	// x / 7650 = (x / 2) / 3825
	assign xh = x[hsvk_pkg::XNUM_W-1:1];

	always_ff @(posedge clk) begin
		plo_s1 <= (XH_W+hsvk_pkg::RECIP_LO_W)'(xh) *
			(XH_W+hsvk_pkg::RECIP_LO_W)'(hsvk_pkg::RECIP_M_LO);
		phi_s1 <= (XH_W+10)'(xh) * (XH_W+10)'(hsvk_pkg::RECIP_M_HI);
	end

	// full product is 41 bits; quotient sits at bits 39:32
	assign sum = {phi_s1, {hsvk_pkg::RECIP_LO_W{1'b0}}} +
		(XH_W+hsvk_pkg::RECIP_LO_W+10)'(plo_s1);

	always_ff @(posedge clk) begin
		q_s2 <= sum[39:32];
	end

	assign q = q_s2;

endmodule

// ----- rtl/core/hsv_range_key_pixel_filter.sv -----
// Top level of the HSV colour-range keying pixel filter.
//
// Usage:
//  - Pixel in: drive pix_in and raise start; the beat is taken on any edge with
//    start high and busy low. busy is never raised, so one pixel per clock.
//  - Pixel out: done is high for one cycle with pix_out once the beat reaches
//    the output register. The receiver cannot hold results off; every beat in
//    gives exactly one beat out, in order.
//  - Config: cfg_we/cfg_index/cfg_wdata write the hue, saturation and value
//    windows; write only while no pixel is in flight. Unknown indexes ignored.
//  - Reset (arst_n low) clears all valid bits and restores the full windows.
// Pipeline:
//  s1 input reg, s2 max/min/hue numerator, s3 window tests (cross-multiplied),
//  8 stages of two restoring dividers (saturation and half-degree hue),
//  s12 sector and coefficients, s13 channel numerators, two stages of
//  reciprocal divide by 7650, then the output register. The dividers resolve
//  one quotient bit per stage; throughput is one beat a clock.
`include "hsv_range_key_pixel_filter_macros.svh"
module hsv_range_key_pixel_filter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  hsvk_pkg::pix_in_t                    pix_in,
	output logic                                 done,
	output hsvk_pkg::pix_out_t                   pix_out,
	input  logic                                 cfg_we,
	input  logic [hsvk_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [hsvk_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	localparam int NDIV = hsvk_pkg::DIV_Q_W;

	// window registers
	logic [8:0] hue_min_q, hue_max_q;
	logic [7:0] sat_min_q, sat_max_q, val_min_q, val_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_min_q <= 9'd0;
			hue_max_q <= 9'd360;
			sat_min_q <= 8'd0;
			sat_max_q <= 8'd255;
			val_min_q <= 8'd0;
			val_max_q <= 8'd255;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hsvk_pkg::REG_HUE_MIN: hue_min_q <= cfg_wdata;
				hsvk_pkg::REG_HUE_MAX: hue_max_q <= cfg_wdata;
				hsvk_pkg::REG_SAT_MIN: sat_min_q <= cfg_wdata[7:0];
				hsvk_pkg::REG_SAT_MAX: sat_max_q <= cfg_wdata[7:0];
				hsvk_pkg::REG_VAL_MIN: val_min_q <= cfg_wdata[7:0];
				hsvk_pkg::REG_VAL_MAX: val_max_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// never stalls
	assign busy = 1'b0;

	// valid chain
	logic            v_s1, v_s2, v_s3, v_s12, v_s13, v_r1, v_r2, done_q;
	logic [NDIV-1:0] v_dv;

	// s1: input register
	hsvk_pkg::pix_in_t pix_s1;

	always_ff @(posedge clk) begin
		pix_s1 <= pix_in;
	end

	// s2: max, min, spread, hue numerator (degrees * spread)
	logic [7:0]         r_c, g_c, b_c, mx_c, mn_c, d_c;
	logic signed [11:0] hue_t;
	logic signed [18:0] n_raw, n_adj;
	logic [16:0]        d360;
	logic [7:0]         mx_s2, d_s2;
	logic [16:0]        n_s2;

	always_comb begin
		r_c  = pix_s1.red_in;
		g_c  = pix_s1.green_in;
		b_c  = pix_s1.blue_in;
		mx_c = r_c;
		if (g_c > mx_c) mx_c = g_c;
		if (b_c > mx_c) mx_c = b_c;
		mn_c = r_c;
		if (g_c < mn_c) mn_c = g_c;
		if (b_c < mn_c) mn_c = b_c;
		d_c = mx_c - mn_c;
		// ties resolve red, then green, then blue
		if (r_c == mx_c) begin
			hue_t = $signed({4'b0, g_c}) - $signed({4'b0, b_c});
		end else if (g_c == mx_c) begin
			hue_t = $signed({3'b0, d_c, 1'b0}) + $signed({4'b0, b_c}) -
				$signed({4'b0, r_c});
		end else begin
			hue_t = $signed({2'b0, d_c, 2'b0}) + $signed({4'b0, r_c}) -
				$signed({4'b0, g_c});
		end
		n_raw = $signed({{7{hue_t[11]}}, hue_t}) * 19'sd60;
		d360  = 17'(d_c) * 17'd360;
		n_adj = n_raw;
		if (n_raw < 0) n_adj = n_raw + $signed({2'b0, d360});
	end

	always_ff @(posedge clk) begin
		mx_s2 <= mx_c;
		d_s2  <= d_c;
		n_s2  <= n_adj[16:0];
	end

	// s3: window tests by cross-multiplication, divider operands
	logic [16:0] hmax_p, hmin_p;
	logic [15:0] sat255, smax_p, smin_p;
	logic        reject_c;
	hsvk_pkg::side_t side_c3, side_s3;
	logic [hsvk_pkg::DIV_NUM_W-1:0] num_sat_s3, num_hue_s3;
	logic [hsvk_pkg::DIV_DEN_W-1:0] den_sat_s3, den_hue_s3;

	always_comb begin
		hmax_p   = 17'(hue_max_q) * 17'(d_s2);
		hmin_p   = 17'(hue_min_q) * 17'(d_s2);
		sat255   = 16'(d_s2) * 16'd255;
		smax_p   = 16'(sat_max_q) * 16'(mx_s2);
		smin_p   = 16'(sat_min_q) * 16'(mx_s2);
		reject_c = (n_s2 > hmax_p) || (n_s2 < hmin_p) ||
			(sat255 > smax_p) || (sat255 < smin_p) ||
			(mx_s2 > val_max_q) || (mx_s2 < val_min_q);
		side_c3.kill = (mx_s2 == 8'd0) || reject_c;
		side_c3.grey = (d_s2 == 8'd0);
		side_c3.vv   = mx_s2;
	end

	always_ff @(posedge clk) begin
		side_s3    <= side_c3;
		num_sat_s3 <= 17'(d_s2) * 17'd510 + 17'(mx_s2);
		den_sat_s3 <= {mx_s2, 1'b0};
		num_hue_s3 <= n_s2 + 17'(d_s2);
		den_hue_s3 <= {d_s2, 1'b0};
	end

	// dividers: rounded saturation and rounded half-degree hue
	logic [hsvk_pkg::DIV_Q_W-1:0] sq_dv, hq_dv;

	hsvk_div u_div_sat (
		.clk  (clk),
		.num  (num_sat_s3),
		.den  (den_sat_s3),
		.quot (sq_dv)
	);

	hsvk_div u_div_hue (
		.clk  (clk),
		.num  (num_hue_s3),
		.den  (den_hue_s3),
		.quot (hq_dv)
	);

	hsvk_pkg::side_t side_dv [NDIV];

	always_ff @(posedge clk) begin
		side_dv[0] <= side_s3;
		for (int i = 1; i < NDIV; i++) begin
			side_dv[i] <= side_dv[i-1];
		end
	end

	// s12: sector, grey detect, channel coefficients
	hsvk_pkg::sect_t sect_c;
	hsvk_pkg::side_t side_c12, side_s12;
	hsvk_pkg::sector_t sec_s12, sec_s13, sec_r1, sec_r2;
	logic [hsvk_pkg::COEF_W-1:0] cp_s12, cq_s12, ct_s12;

	always_comb begin
		sect_c        = hsvk_pkg::hsvk_sector(hq_dv);
		side_c12      = side_dv[NDIV-1];
		side_c12.grey = side_dv[NDIV-1].grey || (sq_dv == 8'd0);
	end

	always_ff @(posedge clk) begin
		side_s12 <= side_c12;
		sec_s12  <= sect_c.sec;
		cp_s12   <= hsvk_pkg::COEF_DEN - 13'(sq_dv) * 13'd30;
		cq_s12   <= hsvk_pkg::COEF_DEN - 13'(sq_dv) * 13'(sect_c.fr);
		ct_s12   <= hsvk_pkg::COEF_DEN - 13'(sq_dv) * 13'(5'd30 - sect_c.fr);
	end

	// s13: numerators with the rounding half added
	hsvk_pkg::side_t side_s13, side_r1, side_r2;
	logic [hsvk_pkg::XNUM_W-1:0] xp_s13, xq_s13, xt_s13;

	always_ff @(posedge clk) begin
		side_s13 <= side_s12;
		sec_s13  <= sec_s12;
		xp_s13   <= 21'(side_s12.vv) * 21'(cp_s12) + hsvk_pkg::ROUND_HALF;
		xq_s13   <= 21'(side_s12.vv) * 21'(cq_s12) + hsvk_pkg::ROUND_HALF;
		xt_s13   <= 21'(side_s12.vv) * 21'(ct_s12) + hsvk_pkg::ROUND_HALF;
	end

	logic [7:0] p_r2, q_r2, t_r2;

	hsvk_recip u_recip_p (.clk(clk), .x(xp_s13), .q(p_r2));
	hsvk_recip u_recip_q (.clk(clk), .x(xq_s13), .q(q_r2));
	hsvk_recip u_recip_t (.clk(clk), .x(xt_s13), .q(t_r2));

	always_ff @(posedge clk) begin
		side_r1 <= side_s13;
		side_r2 <= side_r1;
		sec_r1  <= sec_s13;
		sec_r2  <= sec_r1;
	end

	// output: sector mapping, grey and black overrides
	hsvk_pkg::pix_out_t pix_c, pix_out_q;
	logic [7:0]         vv_c;

	always_comb begin
		vv_c = side_r2.vv;
		case (sec_r2)
			hsvk_pkg::SEC_RED_YEL: pix_c = '{vv_c, t_r2, p_r2};
			hsvk_pkg::SEC_YEL_GRN: pix_c = '{q_r2, vv_c, p_r2};
			hsvk_pkg::SEC_GRN_CYN: pix_c = '{p_r2, vv_c, t_r2};
			hsvk_pkg::SEC_CYN_BLU: pix_c = '{p_r2, q_r2, vv_c};
			hsvk_pkg::SEC_BLU_MAG: pix_c = '{t_r2, p_r2, vv_c};
			default:               pix_c = '{vv_c, p_r2, q_r2};
		endcase
		if (side_r2.kill) begin
			pix_c = '0;
		end else if (side_r2.grey) begin
			pix_c = '{vv_c, vv_c, vv_c};
		end
	end

	always_ff @(posedge clk) begin
		pix_out_q <= pix_c;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_dv   <= '0;
			v_s12  <= 1'b0;
			v_s13  <= 1'b0;
			v_r1   <= 1'b0;
			v_r2   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start && !busy;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_dv   <= {v_dv[NDIV-2:0], v_s3};
			v_s12  <= v_dv[NDIV-1];
			v_s13  <= v_s12;
			v_r1   <= v_s13;
			v_r2   <= v_r1;
			done_q <= v_r2;
		end
	end

	assign done    = done_q;
	assign pix_out = pix_out_q;

	// checks
	`HSVK_ASSERT_NXT(a_last_stage_strobes, clk, arst_n, v_r2, done)
	`HSVK_ASSERT_IMP(a_done_latency, clk, arst_n, done, $past(v_s12, 4))
	`HSVK_ASSERT_IMP(a_kill_is_black, clk, arst_n, v_s12 && side_s12.kill,
		##4 (pix_out.red_out == 8'd0 && pix_out.green_out == 8'd0 && pix_out.blue_out == 8'd0))
	`HSVK_ASSERT_IMP(a_grey_is_flat, clk, arst_n, v_s12 && side_s12.grey,
		##4 (pix_out.red_out == pix_out.green_out && pix_out.green_out == pix_out.blue_out))

endmodule
